// ===== hdl/wrm_pkg.sv =====
`default_nettype none
package wrm_pkg;

	localparam int SAMPLE_BITS    = 10;
	localparam int SQ_BITS        = 2 * SAMPLE_BITS;
	localparam int SUM_BITS       = 28;
	localparam int CNT_BITS       = 9;
	localparam int WLEN_BITS      = 9;
	localparam int SCALE_BITS     = 12;
	localparam int RMS_BITS       = 10;
	localparam int FREQ_BITS      = 12;
	localparam int DVS_BITS       = 10;
	localparam int REM_BITS       = 11;
	localparam int PROD_BITS      = RMS_BITS + SCALE_BITS;
	localparam int MAX_WINDOW     = 256;
	localparam int FS_SHIFT       = 10;
	localparam int FULL_SCALE_DIV = (1 << FS_SHIFT) - 1;
	localparam int FS_Q_BITS      = PROD_BITS - FS_SHIFT + 1;
	localparam int FS_Z_BITS      = FS_SHIFT + 1;
	localparam int DIV_STEPS      = SUM_BITS;
	localparam int SQRT_STEPS     = RMS_BITS;
	localparam int PC_BITS        = 4;
	localparam int LOOP_BITS      = 5;
	localparam int ADDR_BITS      = 3;

	localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 9'd5;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 12'd200;

	// register indexes, taken from paddr[2]
	localparam logic REG_WINDOW_LEN = 1'b0;
	localparam logic REG_FREQ_SCALE = 1'b1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SQUARE,
		OP_ACCUM,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_SQRT_LOAD,
		OP_SQRT_STEP,
		OP_FREQ_LOAD,
		OP_OUT_LOAD
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_WAIT_IN,
		COND_JUMP_SHORT,
		COND_LOOP,
		COND_WAIT_OUT,
		COND_GOTO
	} cond_t;

	typedef enum logic [1:0] {
		LOOP_KEEP,
		LOOP_DIV,
		LOOP_SQRT
	} loop_ld_t;

	typedef struct packed {
		op_t                 op;
		cond_t               cond;
		loop_ld_t            loop_ld;
		logic [PC_BITS-1:0]  target;
	} uword_t;

	typedef struct packed {
		logic short_win;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [WLEN_BITS-1:0]  window_len;
		logic [SCALE_BITS-1:0] freq_scale;
	} cfg_t;

	localparam logic [LOOP_BITS-1:0] DIV_LOOP_INIT  = LOOP_BITS'(DIV_STEPS - 1);
	localparam logic [LOOP_BITS-1:0] SQRT_LOOP_INIT = LOOP_BITS'(SQRT_STEPS - 1);

	// microprogram
	function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
		uword_t w;
		w = '{OP_NOP, COND_GOTO, LOOP_KEEP, 4'd0};
		case (pc)
			4'd0: w = '{OP_SQUARE,    COND_WAIT_IN,    LOOP_KEEP, 4'd0};
			4'd1: w = '{OP_ACCUM,     COND_NEXT,       LOOP_KEEP, 4'd0};
			4'd2: w = '{OP_NOP,       COND_JUMP_SHORT, LOOP_KEEP, 4'd0};
			4'd3: w = '{OP_DIV_LOAD,  COND_NEXT,       LOOP_DIV,  4'd0};
			4'd4: w = '{OP_DIV_STEP,  COND_LOOP,       LOOP_KEEP, 4'd4};
			4'd5: w = '{OP_SQRT_LOAD, COND_NEXT,       LOOP_SQRT, 4'd0};
			4'd6: w = '{OP_SQRT_STEP, COND_LOOP,       LOOP_KEEP, 4'd6};
			4'd7: w = '{OP_FREQ_LOAD, COND_NEXT,       LOOP_KEEP, 4'd0};
			4'd8: w = '{OP_OUT_LOAD,  COND_WAIT_OUT,   LOOP_KEEP, 4'd0};
			default: w = '{OP_NOP, COND_GOTO, LOOP_KEEP, 4'd0};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/wrm_apb_regs.sv =====
`default_nettype none
module wrm_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wrm_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output wrm_pkg::cfg_t                     cfg
);

	logic [wrm_pkg::WLEN_BITS-1:0]  wlen_q;
	logic [wrm_pkg::SCALE_BITS-1:0] scale_q;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= wrm_pkg::WLEN_RESET;
			scale_q <= wrm_pkg::SCALE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				wrm_pkg::REG_WINDOW_LEN: wlen_q  <= pwdata[wrm_pkg::WLEN_BITS-1:0];
				wrm_pkg::REG_FREQ_SCALE: scale_q <= pwdata[wrm_pkg::SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			wrm_pkg::REG_WINDOW_LEN: prdata = {{(32-wrm_pkg::WLEN_BITS){1'b0}}, wlen_q};
			wrm_pkg::REG_FREQ_SCALE: prdata = {{(32-wrm_pkg::SCALE_BITS){1'b0}}, scale_q};
			default:                 prdata = '0;
		endcase
	end

	assign cfg.window_len = wlen_q;
	assign cfg.freq_scale = scale_q;

endmodule
`default_nettype wire

// ===== hdl/wrm_sequencer.sv =====
`default_nettype none
module wrm_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wrm_pkg::status_t      status,
	output logic                  in_ready,
	output wrm_pkg::op_t          op
);

	logic [wrm_pkg::PC_BITS-1:0]   pc_q;
	logic [wrm_pkg::LOOP_BITS-1:0] loop_q;
	wrm_pkg::uword_t               uw;
	logic                          fire;
	logic [wrm_pkg::PC_BITS-1:0]   pc_nxt;

	assign uw       = wrm_pkg::ucode(pc_q);
	assign in_ready = (uw.cond == wrm_pkg::COND_WAIT_IN);

	always_comb begin
		fire   = 1'b1;
		pc_nxt = pc_q + 1'b1;
		case (uw.cond)
			wrm_pkg::COND_NEXT: ;
			wrm_pkg::COND_WAIT_IN: begin
				fire   = in_valid;
				pc_nxt = in_valid ? pc_q + 1'b1 : pc_q;
			end
			wrm_pkg::COND_JUMP_SHORT: begin
				if (status.short_win) pc_nxt = uw.target;
			end
			wrm_pkg::COND_LOOP: begin
				if (loop_q != '0) pc_nxt = uw.target;
			end
			wrm_pkg::COND_WAIT_OUT: begin
				fire   = status.out_free;
				pc_nxt = status.out_free ? uw.target : pc_q;
			end
			wrm_pkg::COND_GOTO: pc_nxt = uw.target;
			default: pc_nxt = '0;
		endcase
	end

	assign op = fire ? uw.op : wrm_pkg::OP_NOP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			loop_q <= '0;
		end else begin
			pc_q <= pc_nxt;
			if (fire) begin
				case (uw.loop_ld)
					wrm_pkg::LOOP_DIV:  loop_q <= wrm_pkg::DIV_LOOP_INIT;
					wrm_pkg::LOOP_SQRT: loop_q <= wrm_pkg::SQRT_LOOP_INIT;
					default: begin
						if (uw.cond == wrm_pkg::COND_LOOP && loop_q != '0)
							loop_q <= loop_q - 1'b1;
					end
				endcase
			end
		end
	end

	property p_loop_only_in_loops;
		@(posedge clk) disable iff (!arst_n)
		(uw.cond == wrm_pkg::COND_LOOP && loop_q != '0) |=> (pc_q == $past(pc_q));
	endproperty
	a_loop_only_in_loops: assert property (p_loop_only_in_loops)
		else $error("loop step did not repeat");

endmodule
`default_nettype wire

// ===== hdl/wrm_datapath.sv =====
`default_nettype none
module wrm_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wrm_pkg::op_t                         op,
	input  wire logic [wrm_pkg::SAMPLE_BITS-1:0] sample,
	input  wrm_pkg::cfg_t                        cfg,
	input  wire logic                            out_ready,
	output wrm_pkg::status_t                     status,
	output logic                                 out_valid,
	output logic [wrm_pkg::RMS_BITS-1:0]         rms_value,
	output logic [wrm_pkg::FREQ_BITS-1:0]        tone_freq
);

	logic [wrm_pkg::SQ_BITS-1:0]    sq_q;
	logic [wrm_pkg::SUM_BITS-1:0]   sum_q;
	logic [wrm_pkg::CNT_BITS-1:0]   cnt_q;
	logic [wrm_pkg::SUM_BITS-1:0]   dvd_q;
	logic [wrm_pkg::DVS_BITS-1:0]   dvs_q;
	logic [wrm_pkg::REM_BITS-1:0]   rem_q;
	logic [wrm_pkg::RMS_BITS-1:0]   root_q;
	logic [wrm_pkg::RMS_BITS-1:0]   rms_q;
	logic [wrm_pkg::FREQ_BITS-1:0]  freq_q;
	logic                           out_valid_q;

	logic [wrm_pkg::CNT_BITS-1:0]   win;
	logic [wrm_pkg::RMS_BITS-1:0]   mul_a;
	logic [wrm_pkg::SCALE_BITS-1:0] mul_b;
	logic [wrm_pkg::PROD_BITS-1:0]  prod;
	logic [wrm_pkg::REM_BITS-1:0]   div_t;
	logic                           div_ge;
	logic [wrm_pkg::REM_BITS+1:0]   sq_r;
	logic [wrm_pkg::REM_BITS+1:0]   sq_t;
	logic                           sq_ge;
	logic [wrm_pkg::FS_Q_BITS-1:0]  fs_y;
	logic [wrm_pkg::FS_Z_BITS-1:0]  fs_z;
	logic                           fs_ge;
	logic [wrm_pkg::FS_Q_BITS-1:0]  fs_q;

	// window length clamped to 1..MAX_WINDOW
	always_comb begin
		if (cfg.window_len == '0)
			win = wrm_pkg::CNT_BITS'(1);
		else if (cfg.window_len > wrm_pkg::WLEN_BITS'(wrm_pkg::MAX_WINDOW))
			win = wrm_pkg::CNT_BITS'(wrm_pkg::MAX_WINDOW);
		else
			win = cfg.window_len;
	end

	// one shared multiplier: sample squared, or rms times scale
	assign mul_a = (op == wrm_pkg::OP_SQUARE) ? sample : root_q;
	assign mul_b = (op == wrm_pkg::OP_SQUARE) ? {2'b00, sample} : cfg.freq_scale;
	assign prod  = mul_a * mul_b;

	// restoring divide, one quotient bit a step
	assign div_t  = {rem_q[wrm_pkg::DVS_BITS-1:0], dvd_q[wrm_pkg::SUM_BITS-1]};
	assign div_ge = div_t >= {1'b0, dvs_q};

	// digit-by-digit square root, two radicand bits a step
	assign sq_r  = {rem_q, dvd_q[wrm_pkg::SQ_BITS-1 -: 2]};
	assign sq_t  = {1'b0, root_q, 2'b01};
	assign sq_ge = sq_r >= sq_t;

	// divide by 1023: x = 1023*(x>>10) + (x>>10) + (x&1023), folded twice,
	// leaving a remainder below 2046 that needs one compare
	assign fs_y  = wrm_pkg::FS_Q_BITS'(dvd_q[wrm_pkg::PROD_BITS-1:wrm_pkg::FS_SHIFT])
	             + wrm_pkg::FS_Q_BITS'(dvd_q[wrm_pkg::FS_SHIFT-1:0]);
	assign fs_z  = wrm_pkg::FS_Z_BITS'(fs_y[wrm_pkg::FS_Q_BITS-1:wrm_pkg::FS_SHIFT])
	             + wrm_pkg::FS_Z_BITS'(fs_y[wrm_pkg::FS_SHIFT-1:0]);
	assign fs_ge = fs_z >= wrm_pkg::FS_Z_BITS'(wrm_pkg::FULL_SCALE_DIV);
	assign fs_q  = wrm_pkg::FS_Q_BITS'(dvd_q[wrm_pkg::PROD_BITS-1:wrm_pkg::FS_SHIFT])
	             + wrm_pkg::FS_Q_BITS'(fs_y[wrm_pkg::FS_Q_BITS-1:wrm_pkg::FS_SHIFT])
	             + wrm_pkg::FS_Q_BITS'(fs_ge);

	assign status.short_win = cnt_q < win;
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == wrm_pkg::OP_OUT_LOAD)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (op)
				wrm_pkg::OP_ACCUM: begin
					sum_q <= sum_q + {{(wrm_pkg::SUM_BITS-wrm_pkg::SQ_BITS){1'b0}}, sq_q};
					cnt_q <= cnt_q + 1'b1;
				end
				wrm_pkg::OP_DIV_LOAD: begin
					sum_q <= '0;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			wrm_pkg::OP_SQUARE: sq_q <= prod[wrm_pkg::SQ_BITS-1:0];
			wrm_pkg::OP_DIV_LOAD: begin
				dvd_q <= sum_q;
				dvs_q <= {1'b0, cnt_q};
				rem_q <= '0;
			end
			wrm_pkg::OP_DIV_STEP: begin
				rem_q <= div_ge ? div_t - {1'b0, dvs_q} : div_t;
				dvd_q <= {dvd_q[wrm_pkg::SUM_BITS-2:0], div_ge};
			end
			wrm_pkg::OP_SQRT_LOAD: begin
				rem_q  <= '0;
				root_q <= '0;
			end
			wrm_pkg::OP_SQRT_STEP: begin
				rem_q  <= sq_ge ? wrm_pkg::REM_BITS'(sq_r - sq_t)
				                : sq_r[wrm_pkg::REM_BITS-1:0];
				root_q <= {root_q[wrm_pkg::RMS_BITS-2:0], sq_ge};
				dvd_q  <= {dvd_q[wrm_pkg::SUM_BITS-3:0], 2'b00};
			end
			wrm_pkg::OP_FREQ_LOAD: begin
				dvd_q <= {{(wrm_pkg::SUM_BITS-wrm_pkg::PROD_BITS){1'b0}}, prod};
			end
			wrm_pkg::OP_OUT_LOAD: begin
				rms_q  <= root_q;
				freq_q <= (fs_q > wrm_pkg::FS_Q_BITS'({wrm_pkg::FREQ_BITS{1'b1}}))
				          ? {wrm_pkg::FREQ_BITS{1'b1}} : fs_q[wrm_pkg::FREQ_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign rms_value = rms_q;
	assign tone_freq = freq_q;

	property p_rem_below_divisor;
		@(posedge clk) disable iff (!arst_n)
		(op == wrm_pkg::OP_DIV_STEP) |-> ({1'b0, rem_q} < {2'b00, dvs_q});
	endproperty
	a_rem_below_divisor: assert property (p_rem_below_divisor)
		else $error("divider remainder not below divisor");

	property p_window_cleared;
		@(posedge clk) disable iff (!arst_n)
		(op == wrm_pkg::OP_DIV_LOAD) |=> (sum_q == '0 && cnt_q == '0);
	endproperty
	a_window_cleared: assert property (p_window_cleared)
		else $error("accumulator not cleared after window");

	property p_count_bounded;
		@(posedge clk) disable iff (!arst_n)
		cnt_q <= wrm_pkg::CNT_BITS'(wrm_pkg::MAX_WINDOW);
	endproperty
	a_count_bounded: assert property (p_count_bounded)
		else $error("sample count beyond window limit");

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n)
		(op == wrm_pkg::OP_OUT_LOAD) |-> (!out_valid_q || out_ready);
	endproperty
	a_no_overwrite: assert property (p_no_overwrite)
		else $error("result register overwritten while held");

endmodule
`default_nettype wire

// ===== hdl/windowed_rms_meter.sv =====
// channel   dir  signals                         contents
// s_axis    in   s_tvalid s_tready s_tdata[15:0]  [9:0] sample
// m_axis    out  m_tvalid m_tready m_tdata[23:0]  [9:0] rms_value, [21:10] tone_freq
// apb       in   psel penable pwrite paddr pwdata 0x0 window_len, 0x4 freq_scale
//
// A sample that does not close a window is squared, accumulated and tested.
// A sample that closes a window goes on to 28 divide steps for the mean and
// 10 root steps that share one datapath, run by the microcode loop counter; then
// rms * scale is formed and folded by 1023 into the result register.
// Reset clears the accumulator, count and sequencer; registers return to 5 and 200.
// The result register is one deep: samples keep being taken while a result waits,
// and only the end of the next window stalls until m_tready drains it.
`default_nettype none
module windowed_rms_meter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,   // [9:0] sample
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [23:0]                   m_tdata,   // [9:0] rms_value, [21:10] tone_freq
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wrm_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	wrm_pkg::cfg_t                     cfg;
	wrm_pkg::status_t                  status;
	wrm_pkg::op_t                      op;
	logic [wrm_pkg::RMS_BITS-1:0]      rms_value;
	logic [wrm_pkg::FREQ_BITS-1:0]     tone_freq;

	// configuration registers
	wrm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step counter, loop counter and microcode table
	wrm_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.in_ready (s_tready),
		.op       (op)
	);

	// accumulator, shared multiplier, divide and root step logic, result register
	wrm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.sample    (s_tdata[wrm_pkg::SAMPLE_BITS-1:0]),
		.cfg       (cfg),
		.out_ready (m_tready),
		.status    (status),
		.out_valid (m_tvalid),
		.rms_value (rms_value),
		.tone_freq (tone_freq)
	);

	assign m_tdata = {2'b00, tone_freq, rms_value};

endmodule
`default_nettype wire
